// ===== rtl/core/deq_pkg.sv =====
// Shared types, constants and action codes for the double-ended queue core.
// Used by deq_ctrl, deq_ram and double_ended_queue_core; depends on nothing.
package deq_pkg;

    localparam int DEPTH   = 1024;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int ACT_W   = 3;
    localparam int STAT_W  = 2;
    localparam int OUT_W   = DATA_W + STAT_W + CNT_W + 1;
    localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_PEEK_FRONT = 3'd4,
        ACT_PEEK_BACK  = 3'd5
    } t_action;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [IDX_W-1:0]  waddr;
        logic [IDX_W-1:0]  raddr;
        logic [DATA_W-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic              is_read;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
        logic              is_empty;
    } t_meta;

endpackage

// ===== rtl/core/double_ended_queue_core.sv =====
// Top level of the double-ended queue core: stream ports, read stage, result register.
// Depends on deq_pkg, deq_ctrl and deq_ram.
//
// Each input transaction carries one action in s_axis_tuser (push front, push back,
// pop front, pop back, peek front, peek back) and a push value in s_axis_tdata.
// Every action yields exactly one output transaction with the value read, a status
// (ok, empty, full), the entry count after the action and an empty flag.
// Pops and peeks on an empty queue and pushes onto a full queue leave the queue
// unchanged and report the matching status; unused action codes report ok.
// The block accepts one action per cycle while o_s_axis_tready is high. The result
// passes through the registered memory read and then the result register. Pointer
// and count updates happen at the accepting edge, so an action sees the effect of
// the one just before it.
// When the receiver stalls, the result register and the read stage hold; the input
// stays ready until both are occupied, so up to two results can be waiting.
// Reset empties the queue and clears both stages; memory contents are not cleared.
module double_ended_queue_core import deq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // [31:0] push_value
    input  logic [DATA_W-1:0]  i_s_axis_tdata,
    // [2:0] action
    input  logic [ACT_W-1:0]   i_s_axis_tuser,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // [31:0] read_value, [33:32] status, [44:34] entry_count, [45] is_empty, rest zero
    output logic [OUT_PAD-1:0] o_m_axis_tdata
);

    logic              accept;
    logic              s1_adv;
    t_mem_req          mem_req;
    t_meta             meta;
    logic [DATA_W-1:0] ram_q;

    logic              r_s1_valid;
    t_meta             r_s1_meta;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic [DATA_W-1:0] rd_value;

    assign s1_adv          = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    deq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_action (i_s_axis_tuser),
        .i_value  (i_s_axis_tdata),
        .o_mem    (mem_req),
        .o_meta   (meta)
    );

    deq_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_meta <= meta;
        end
    end

    assign rd_value = r_s1_meta.is_read ? ram_q : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_data <= {r_s1_meta.is_empty, r_s1_meta.count, r_s1_meta.status, rd_value};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_PAD - OUT_W){1'b0}}, r_out_data};

endmodule

// ===== rtl/core/deq_ctrl.sv =====
// Front/back index and count bookkeeping for the double-ended queue.
// Issues one memory request per transaction; depends on deq_pkg.
module deq_ctrl import deq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [DATA_W-1:0] i_value,
    output t_mem_req          o_mem,
    output t_meta             o_meta
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [IDX_W-1:0] r_front, n_front;
    logic [IDX_W-1:0] r_back, n_back;
    logic [CNT_W-1:0] r_count, n_count;

    logic             full;
    logic             empty;
    logic [IDX_W-1:0] front_inc;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] back_inc;
    logic [IDX_W-1:0] back_dec;

    assign full      = (r_count == FULL_CNT);
    assign empty     = (r_count == '0);
    assign front_inc = (r_front == LAST_IDX) ? '0 : r_front + IDX_W'(1);
    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - IDX_W'(1);
    assign back_inc  = (r_back == LAST_IDX) ? '0 : r_back + IDX_W'(1);
    assign back_dec  = (r_back == '0) ? LAST_IDX : r_back - IDX_W'(1);

    always_comb begin
        n_front        = r_front;
        n_back         = r_back;
        n_count        = r_count;
        o_mem.we       = 1'b0;
        o_mem.re       = i_accept;
        o_mem.waddr    = r_back;
        o_mem.raddr    = r_front;
        o_mem.wdata    = i_value;
        o_meta.is_read = 1'b0;
        o_meta.status  = ST_OK;
        case (i_action)
            ACT_PUSH_FRONT: begin
                if (full) begin
                    o_meta.status = ST_FULL;
                end else begin
                    n_front     = front_dec;
                    o_mem.we    = i_accept;
                    o_mem.waddr = front_dec;
                    n_count     = r_count + CNT_W'(1);
                end
            end
            ACT_PUSH_BACK: begin
                if (full) begin
                    o_meta.status = ST_FULL;
                end else begin
                    n_back      = back_inc;
                    o_mem.we    = i_accept;
                    o_mem.waddr = r_back;
                    n_count     = r_count + CNT_W'(1);
                end
            end
            ACT_POP_FRONT: begin
                if (empty) begin
                    o_meta.status = ST_EMPTY;
                end else begin
                    o_meta.is_read = 1'b1;
                    o_mem.raddr    = r_front;
                    n_front        = front_inc;
                    n_count        = r_count - CNT_W'(1);
                end
            end
            ACT_POP_BACK: begin
                if (empty) begin
                    o_meta.status = ST_EMPTY;
                end else begin
                    o_meta.is_read = 1'b1;
                    o_mem.raddr    = back_dec;
                    n_back         = back_dec;
                    n_count        = r_count - CNT_W'(1);
                end
            end
            ACT_PEEK_FRONT: begin
                if (empty) begin
                    o_meta.status = ST_EMPTY;
                end else begin
                    o_meta.is_read = 1'b1;
                    o_mem.raddr    = r_front;
                end
            end
            ACT_PEEK_BACK: begin
                if (empty) begin
                    o_meta.status = ST_EMPTY;
                end else begin
                    o_meta.is_read = 1'b1;
                    o_mem.raddr    = back_dec;
                end
            end
            default: begin
            end
        endcase
        o_meta.count    = n_count;
        o_meta.is_empty = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/core/deq_ram.sv =====
// Entry store of the double-ended queue: one write and one registered read port.
// Depends on deq_pkg for depth, widths and the request struct.
module deq_ram import deq_pkg::*; (
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue_core, with a directed table and random phases.
// Depends on deq_pkg and the double_ended_queue_core RTL.
module tb_top;
    import deq_pkg::*;

    localparam logic [ACT_W-1:0] ACT_NOP_A = 3'd6;
    localparam logic [ACT_W-1:0] ACT_NOP_B = 3'd7;
    localparam int               MAX_SHOWN = 10;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
        logic              is_empty;
    } t_deq_result;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [DATA_W-1:0] val;
        logic              typed;
        t_deq_result       exp;
    } t_step_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [DATA_W-1:0]  i_s_axis_tdata = '0;
    logic [ACT_W-1:0]   i_s_axis_tuser = '0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [OUT_PAD-1:0] o_m_axis_tdata;

    logic               row_typed = 1'b0;
    t_deq_result        row_exp = '0;

    logic [DATA_W-1:0]  model_ring [DEPTH];
    logic [IDX_W-1:0]   head_idx = '0;
    logic [IDX_W-1:0]   tail_idx = '0;
    logic [CNT_W-1:0]   model_count = '0;
    t_deq_result        pending_results [$];

    int                 fault_count = 0;
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;
    t_deq_result        got;
    t_deq_result        want;
    t_deq_result        pred;

    t_step_row directed_rows [23] = '{
        '{ACT_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY, 11'd0, 1'b1}},
        '{ACT_POP_BACK,   32'hFFFF_FFFF, 1'b1, '{32'h0, ST_EMPTY, 11'd0, 1'b1}},
        '{ACT_PEEK_FRONT, 32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY, 11'd0, 1'b1}},
        '{ACT_PEEK_BACK,  32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY, 11'd0, 1'b1}},
        '{ACT_NOP_A,      32'h1234_5678, 1'b1, '{32'h0, ST_OK,    11'd0, 1'b1}},
        '{ACT_NOP_B,      32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OK,    11'd0, 1'b1}},
        '{ACT_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, '{32'h0, ST_OK,    11'd1, 1'b0}},
        '{ACT_PUSH_FRONT, 32'h8000_0000, 1'b1, '{32'h0, ST_OK,    11'd2, 1'b0}},
        '{ACT_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OK,    11'd3, 1'b0}},
        '{ACT_PUSH_FRONT, 32'h0000_0000, 1'b1, '{32'h0, ST_OK,    11'd4, 1'b0}},
        '{ACT_PEEK_FRONT, 32'h0000_0000, 1'b0, '0},
        '{ACT_PEEK_BACK,  32'h0000_0000, 1'b0, '0},
        '{ACT_POP_FRONT,  32'hDEAD_BEEF, 1'b0, '0},
        '{ACT_POP_BACK,   32'h0000_0000, 1'b0, '0},
        '{ACT_POP_FRONT,  32'h0000_0000, 1'b0, '0},
        '{ACT_POP_BACK,   32'h0000_0000, 1'b0, '0},
        '{ACT_POP_BACK,   32'h0000_0000, 1'b1, '{32'h0, ST_EMPTY, 11'd0, 1'b1}},
        '{ACT_PUSH_FRONT, 32'hA5A5_A5A5, 1'b0, '0},
        '{ACT_PEEK_BACK,  32'h0000_0000, 1'b0, '0},
        '{ACT_POP_BACK,   32'h0000_0000, 1'b0, '0},
        '{ACT_PUSH_BACK,  32'h5A5A_5A5A, 1'b0, '0},
        '{ACT_NOP_B,      32'h0000_0000, 1'b0, '0},
        '{ACT_POP_FRONT,  32'h0000_0000, 1'b0, '0}
    };

    double_ended_queue_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        return (int'(idx) + 1 >= DEPTH) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
    endfunction

    function automatic t_deq_result deq_apply(input logic [ACT_W-1:0] act,
                                              input logic [DATA_W-1:0] val);
        t_deq_result r;
        logic        full;
        logic        empty;
        r = '0;
        r.status = ST_OK;
        full = (int'(model_count) >= DEPTH);
        empty = (model_count == '0);
        case (act)
            ACT_PUSH_FRONT: begin
                if (full) begin
                    r.status = ST_FULL;
                end else begin
                    head_idx = ring_prev(head_idx);
                    model_ring[head_idx] = val;
                    model_count = model_count + 1'b1;
                end
            end
            ACT_PUSH_BACK: begin
                if (full) begin
                    r.status = ST_FULL;
                end else begin
                    model_ring[tail_idx] = val;
                    tail_idx = ring_next(tail_idx);
                    model_count = model_count + 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (empty) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_value = model_ring[head_idx];
                    head_idx = ring_next(head_idx);
                    model_count = model_count - 1'b1;
                end
            end
            ACT_POP_BACK: begin
                if (empty) begin
                    r.status = ST_EMPTY;
                end else begin
                    tail_idx = ring_prev(tail_idx);
                    r.read_value = model_ring[tail_idx];
                    model_count = model_count - 1'b1;
                end
            end
            ACT_PEEK_FRONT: begin
                if (empty) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_value = model_ring[head_idx];
                end
            end
            ACT_PEEK_BACK: begin
                if (empty) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_value = model_ring[ring_prev(tail_idx)];
                end
            end
            default: begin
            end
        endcase
        r.count = model_count;
        r.is_empty = (model_count == '0);
        return r;
    endfunction

    function automatic logic [ACT_W-1:0] pick_action();
        int r;
        r = $urandom_range(99);
        if (r < 20) return ACT_PUSH_FRONT;
        if (r < 40) return ACT_PUSH_BACK;
        if (r < 55) return ACT_POP_FRONT;
        if (r < 70) return ACT_POP_BACK;
        if (r < 80) return ACT_PEEK_FRONT;
        if (r < 90) return ACT_PEEK_BACK;
        if (r < 95) return ACT_NOP_A;
        return ACT_NOP_B;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ACT_W-1:0] pick_push();
        return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    endfunction

    function automatic logic [ACT_W-1:0] pick_drain();
        int r;
        r = $urandom_range(99);
        if (r < 42) return ACT_POP_FRONT;
        if (r < 85) return ACT_POP_BACK;
        if (r < 95) return pick_push();
        return $urandom_range(1) ? ACT_PEEK_BACK : ACT_PEEK_FRONT;
    endfunction

    task automatic set_phase(input int mode);
        send_idle_pct = (mode == 1) ? 77 : (mode == 3) ? 7 : 0;
        stall_pct = (mode == 2) ? 77 : (mode == 3) ? 7 : 0;
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_action(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val,
                               input logic typed, input t_deq_result exp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= val;
        i_s_axis_tuser <= act;
        row_typed <= typed;
        row_exp <= exp;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic wait_results();
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic report_fault(input string what);
        fault_count++;
        if (fault_count <= MAX_SHOWN) $display("%t mismatch: %s", $realtime, what);
    endtask

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready === 1'b1) begin
                pred = deq_apply(i_s_axis_tuser, i_s_axis_tdata);
                pending_results.push_back(row_typed ? row_exp : pred);
            end
            if (o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
                got.read_value = o_m_axis_tdata[DATA_W-1:0];
                got.status     = o_m_axis_tdata[DATA_W +: STAT_W];
                got.count      = o_m_axis_tdata[DATA_W+STAT_W +: CNT_W];
                got.is_empty   = o_m_axis_tdata[OUT_W-1];
                if (pending_results.size() == 0) begin
                    report_fault($sformatf("unexpected result %h", o_m_axis_tdata));
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (got.read_value !== want.read_value || got.status !== want.status ||
                        got.count !== want.count || got.is_empty !== want.is_empty ||
                        o_m_axis_tdata[OUT_PAD-1:OUT_W] !== '0) begin
                        report_fault($sformatf(
                            "exp %h %0d %0d %0d, got %h %0d %0d %0d pad %b",
                            want.read_value, want.status, want.count, want.is_empty,
                            got.read_value, got.status, got.count, got.is_empty,
                            o_m_axis_tdata[OUT_PAD-1:OUT_W]));
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("[double_ended_queue_core] ERROR");
        $finish;
    end

    initial begin
        set_phase(0);
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < $size(directed_rows); k++) begin
            send_action(directed_rows[k].act, directed_rows[k].val,
                        directed_rows[k].typed, directed_rows[k].exp);
        end
        wait_results();

        for (int mode = 0; mode < 4; mode++) begin
            set_phase(mode);
            repeat (100) send_action(pick_action(), pick_value(), 1'b0, '0);
            wait_results();
        end

        // Fill the ring to the top, push against it, peek both ends, then drain it to empty and pop and peek once more.
        set_phase(3);
        while (int'(model_count) < DEPTH) send_action(pick_push(), pick_value(), 1'b0, '0);
        repeat (3) send_action(pick_push(), pick_value(), 1'b0, '0);
        send_action(ACT_PEEK_FRONT, pick_value(), 1'b0, '0);
        send_action(ACT_PEEK_BACK, pick_value(), 1'b0, '0);
        while (model_count != '0) send_action(pick_drain(), pick_value(), 1'b0, '0);
        send_action(ACT_POP_FRONT, pick_value(), 1'b0, '0);
        send_action(ACT_PEEK_BACK, pick_value(), 1'b0, '0);
        wait_results();

        repeat (8) @(posedge i_clk);
        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("[double_ended_queue_core] OK");
        end else begin
            $display("[double_ended_queue_core] ERROR");
        end
        $finish;
    end

endmodule
